[rtl/core/sbda_pkg.sv]
// Shared types and constants for the signed binary to decimal text converter.
package sbda_pkg;

    localparam int unsigned MagW = 32;
    localparam int unsigned PosW = 4;
    localparam int unsigned ThrW = 36;
    localparam int unsigned NumDigits = 10;

    localparam logic [7:0] C_CHAR_ZERO  = 8'h30;
    localparam logic [7:0] C_CHAR_MINUS = 8'h2D;

    // powers of ten, wide enough that 9 * 10^9 still fits
    localparam logic [ThrW-1:0] C_POW10 [NumDigits] = '{
        36'd1,
        36'd10,
        36'd100,
        36'd1000,
        36'd10000,
        36'd100000,
        36'd1000000,
        36'd10000000,
        36'd100000000,
        36'd1000000000
    };

    // one queued item: sign, magnitude and index of its leading digit
    typedef struct packed {
        logic            neg;
        logic [MagW-1:0] mag;
        logic [PosW-1:0] pos;
    } t_entry;

endpackage

[rtl/core/signed_binary_to_decimal_ascii.sv]
// Top level: signed 32-bit integer in, decimal ASCII characters out.
//
// Input channel (i_valid / o_ready / i_value) takes one signed 32-bit item.
// Output channel (o_valid / i_ready / o_char_code / o_last) gives its text,
// one character per item: '-' for a negative value, then the digits most
// significant first without leading zeros. Zero gives a single '0'. o_last
// marks the final character of each number.
// An item passes the front register, queue and output register before
// its first character shows on o_valid. A number has 1 to 11 characters
// (sign plus up to ten digits). The digit generator makes one character
// per cycle while i_ready is high, so the output channel sets the rate
// and numbers follow with no gap. A two-entry queue sits between the
// front end and digit generator, so inputs are taken while characters drain.
// When the receiver holds i_ready low, the current character stays on the
// outputs unchanged and the block stops pulling from the queue; o_ready
// drops once the front register and the queue are full.
// Reset (synchronous, active low) empties the pipeline; pending items and
// characters are dropped.
module signed_binary_to_decimal_ascii (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_char_code,
    output logic               o_last
);
    import sbda_pkg::*;

    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_nonempty;
    t_entry w_entry;
    t_entry w_head;

    sbda_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_push  (w_push),
        .o_entry (w_entry),
        .i_full  (w_full)
    );

    sbda_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_entry    (w_entry),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    sbda_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (w_nonempty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

[rtl/core/sbda_front.sv]
// Front end: takes an item, forms sign and magnitude, finds the leading digit.
module sbda_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [31:0]    i_value,
    output logic                  o_push,
    output sbda_pkg::t_entry      o_entry,
    input  logic                  i_full
);
    import sbda_pkg::*;

    logic              r_valid;
    logic [MagW-1:0]   r_value;
    logic              w_neg;
    logic [MagW-1:0]   w_mag;
    logic [PosW-1:0]   w_pos;

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_value <= i_value;
        end
    end

    always_comb begin
        w_neg = r_value[MagW-1];
        w_mag = w_neg ? (MagW'(0) - r_value) : r_value;
        w_pos = '0;
        for (int k = 1; k < NumDigits; k++) begin
            if ({{(ThrW-MagW){1'b0}}, w_mag} >= C_POW10[k]) begin
                w_pos = PosW'(k);
            end
        end
    end

    assign o_entry = '{neg: w_neg, mag: w_mag, pos: w_pos};

endmodule

[rtl/core/sbda_queue.sv]
// Two-entry queue between front end and digit generator.
module sbda_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sbda_pkg::t_entry i_entry,
    output logic             o_full,
    output logic             o_nonempty,
    output sbda_pkg::t_entry o_head,
    input  logic             i_pop
);
    import sbda_pkg::*;

    t_entry       r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;

    assign o_full     = (r_count == 2'd2);
    assign o_nonempty = (r_count != 2'd0);
    assign o_head     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

[rtl/core/sbda_back.sv]
// Digit generator: emits sign and digits, one character per cycle while i_ready allows.
module sbda_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_nonempty,
    input  sbda_pkg::t_entry i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_char_code,
    output logic             o_last
);
    import sbda_pkg::*;

    logic              r_busy;
    logic              r_neg;
    logic [MagW-1:0]   r_rem;
    logic [PosW-1:0]   r_pos;
    logic              r_out_valid;
    logic [7:0]        r_char;
    logic              r_last;

    logic              n_busy;
    logic              n_neg;
    logic [MagW-1:0]   n_rem;
    logic [PosW-1:0]   n_pos;
    logic [7:0]        n_char;
    logic              n_last;

    logic              w_adv;
    logic              w_active;
    logic              w_cur_neg;
    logic [MagW-1:0]   w_cur_rem;
    logic [PosW-1:0]   w_cur_pos;
    logic [3:0]        w_digit;
    logic [ThrW-1:0]   w_mult [NumDigits][NumDigits];

    // multiples k * 10^p, constant table
    for (genvar p = 0; p < NumDigits; p++) begin : g_pos
        for (genvar k = 0; k < NumDigits; k++) begin : g_k
            assign w_mult[p][k] = C_POW10[p] * ThrW'(k);
        end
    end

    assign w_adv     = !r_out_valid || i_ready;
    assign w_active  = r_busy || i_nonempty;
    assign w_cur_neg = r_busy ? r_neg : i_head.neg;
    assign w_cur_rem = r_busy ? r_rem : i_head.mag;
    assign w_cur_pos = r_busy ? r_pos : i_head.pos;
    assign o_pop     = w_adv && !r_busy && i_nonempty;

    always_comb begin
        w_digit = '0;
        for (int k = 1; k < NumDigits; k++) begin
            if ({{(ThrW-MagW){1'b0}}, w_cur_rem} >= w_mult[w_cur_pos][k]) begin
                w_digit = 4'(k);
            end
        end

        n_busy = r_busy;
        n_neg  = r_neg;
        n_rem  = r_rem;
        n_pos  = r_pos;
        n_char = r_char;
        n_last = r_last;
        if (w_adv && w_active) begin
            if (w_cur_neg) begin
                // sign first; digits follow from the same magnitude
                n_char = C_CHAR_MINUS;
                n_last = 1'b0;
                n_busy = 1'b1;
                n_neg  = 1'b0;
                n_rem  = w_cur_rem;
                n_pos  = w_cur_pos;
            end else begin
                n_char = C_CHAR_ZERO + {4'b0, w_digit};
                n_last = (w_cur_pos == '0);
                n_busy = (w_cur_pos != '0);
                n_neg  = 1'b0;
                n_rem  = MagW'(({{(ThrW-MagW){1'b0}}, w_cur_rem}
                               - w_mult[w_cur_pos][w_digit]));
                n_pos  = w_cur_pos - PosW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (w_adv) begin
                r_out_valid <= w_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_rem  <= n_rem;
        r_pos  <= n_pos;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule
